### hw/rtl/pmrt_pkg.sv
// Package for the per-minute message rate table.
// Holds the widths, the divider reciprocals and the command and status structs.
// No dependencies.
package pmrt_pkg;

    // Bucket ring geometry.
    localparam int NUM_BUCKETS        = 1440;
    localparam int SECONDS_PER_BUCKET = 60;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int COUNT_W = 32;
    localparam int TAG_W   = 27;
    localparam int SLOT_W  = $clog2(NUM_BUCKETS);
    localparam int WORD_W  = COUNT_W + TAG_W;
    localparam int LO_W    = TAG_W + 2;

    // Reciprocal for seconds / SECONDS_PER_BUCKET, exact for every 32-bit time.
    localparam int MIN_SHIFT   = TIME_W + $clog2(SECONDS_PER_BUCKET);
    localparam int MIN_MAGIC_W = TIME_W + 1;
    localparam int MIN_PROD_W  = MIN_SHIFT + TAG_W;
    localparam longint unsigned MIN_MAGIC_L =
        ((64'd1 << MIN_SHIFT) + 64'(SECONDS_PER_BUCKET) - 64'd1) / 64'(SECONDS_PER_BUCKET);
    localparam logic [MIN_MAGIC_W-1:0] MIN_MAGIC = MIN_MAGIC_W'(MIN_MAGIC_L);

    // Reciprocal for minute / NUM_BUCKETS, exact for every TAG_W-bit minute.
    localparam int SLOT_SHIFT   = TAG_W + SLOT_W;
    localparam int SLOT_MAGIC_W = TAG_W + 2;
    localparam int SLOT_PROD_W  = SLOT_SHIFT + TAG_W;
    localparam longint unsigned SLOT_MAGIC_L =
        ((64'd1 << SLOT_SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [SLOT_MAGIC_W-1:0] SLOT_MAGIC = SLOT_MAGIC_W'(SLOT_MAGIC_L);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUCKETS - 1);

    // Operation codes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;       // capture the input word
        logic do_minute;    // register the minute number
        logic do_quot;      // register minute / NUM_BUCKETS
        logic do_slot;      // register the slot and the window lower bound
        logic cnt_clear;    // reset the bucket index counter
        logic cnt_inc;      // advance the bucket index counter
        logic rd_slot;      // read the bucket at the slot
        logic rd_cnt;       // read the bucket at the index counter
        logic wr_clear;     // write zero at the index counter
        logic wr_add;       // write the updated bucket and bump the totals
        logic acc_clear;    // zero the window sum
        logic finish;       // load the result registers and strobe
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;     // index counter is at the last bucket
        logic is_query;     // captured word is a query
    } t_sts;

endpackage

### hw/rtl/per_minute_message_rate_table.sv
// Top level of the per-minute message rate table.
// Depends on pmrt_pkg, pmrt_ctrl and pmrt_datapath.
//
// A word is accepted when start is high and busy is low. After reset the block
// holds busy while it clears all NUM_BUCKETS (1440) buckets of the store.
// An add word passes the minute, quotient, slot, read, write and finish states
// before the next acceptance; a query word passes the minute, quotient and slot
// states, a scan that reads one bucket per cycle through the single read port of
// the bucket store, and the scan end and finish states. Each result is shown for
// exactly one cycle with o_valid high and cannot be held off; busy falls in that
// same cycle, so the next word may be accepted while the result is on the ports.
module per_minute_message_rate_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [pmrt_pkg::TIME_W-1:0]     i_time_seconds,
    input  logic [pmrt_pkg::WIN_W-1:0]      i_window_minutes,
    output logic                            o_valid,
    output logic [pmrt_pkg::COUNT_W-1:0]    o_window_count,
    output logic [pmrt_pkg::COUNT_W-1:0]    o_total_count,
    output logic [pmrt_pkg::TIME_W-1:0]     o_first_time,
    output logic [pmrt_pkg::TIME_W-1:0]     o_last_time
);

    pmrt_pkg::t_cmd w_cmd;
    pmrt_pkg::t_sts w_sts;

    // Sequencer.
    pmrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Arithmetic, bucket store and result registers.
    pmrt_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_opcode),
        .i_time_seconds   (i_time_seconds),
        .i_window_minutes (i_window_minutes),
        .o_valid          (o_valid),
        .o_window_count   (o_window_count),
        .o_total_count    (o_total_count),
        .o_first_time     (o_first_time),
        .o_last_time      (o_last_time)
    );

endmodule

### hw/rtl/pmrt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/pmrt_ctrl.sv
// Controller state machine for the per-minute message rate table.
// Depends on pmrt_pkg for the command and status structs.
module pmrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pmrt_pkg::t_sts  i_sts,
    output pmrt_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_MINUTE   = 4'd2;
    localparam logic [3:0] ST_QUOT     = 4'd3;
    localparam logic [3:0] ST_SLOT     = 4'd4;
    localparam logic [3:0] ST_ADD_RD   = 4'd5;
    localparam logic [3:0] ST_ADD_WR   = 4'd6;
    localparam logic [3:0] ST_SCAN     = 4'd7;
    localparam logic [3:0] ST_SCAN_END = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0]      r_state;
    logic [3:0]      n_state;
    pmrt_pkg::t_cmd  w_cmd;

    // State register; reset starts the clearing sweep of the bucket store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                w_cmd.wr_clear = 1'b1;
                w_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    w_cmd.cnt_clear = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    w_cmd.cap_in = 1'b1;
                    n_state      = ST_MINUTE;
                end
            end
            ST_MINUTE: begin
                w_cmd.do_minute = 1'b1;
                n_state         = ST_QUOT;
            end
            ST_QUOT: begin
                w_cmd.do_quot = 1'b1;
                n_state       = ST_SLOT;
            end
            ST_SLOT: begin
                w_cmd.do_slot   = 1'b1;
                w_cmd.cnt_clear = 1'b1;
                w_cmd.acc_clear = 1'b1;
                n_state         = i_sts.is_query ? ST_SCAN : ST_ADD_RD;
            end
            ST_ADD_RD: begin
                w_cmd.rd_slot = 1'b1;
                n_state       = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                w_cmd.wr_add = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_SCAN: begin
                w_cmd.rd_cnt  = 1'b1;
                w_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) begin
                    w_cmd.cnt_clear = 1'b1;
                    n_state         = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                // The last bucket read lands in the sum this cycle.
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                w_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

### hw/rtl/pmrt_datapath.sv
// Datapath for the per-minute message rate table: minute and slot arithmetic,
// the bucket store, the window sum and the result registers.
// Depends on pmrt_pkg and pmrt_ram.
module pmrt_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmrt_pkg::t_cmd                  i_cmd,
    output pmrt_pkg::t_sts                  o_sts,
    input  logic                            i_opcode,
    input  logic [pmrt_pkg::TIME_W-1:0]     i_time_seconds,
    input  logic [pmrt_pkg::WIN_W-1:0]      i_window_minutes,
    output logic                            o_valid,
    output logic [pmrt_pkg::COUNT_W-1:0]    o_window_count,
    output logic [pmrt_pkg::COUNT_W-1:0]    o_total_count,
    output logic [pmrt_pkg::TIME_W-1:0]     o_first_time,
    output logic [pmrt_pkg::TIME_W-1:0]     o_last_time
);

    // Captured input word.
    logic                                r_op;
    logic [pmrt_pkg::TIME_W-1:0]         r_secs;
    logic [pmrt_pkg::WIN_W-1:0]          r_win;

    // Arithmetic stages.
    logic [pmrt_pkg::TAG_W-1:0]          r_minute;
    logic [pmrt_pkg::TAG_W-1:0]          r_quot;
    logic [pmrt_pkg::SLOT_W-1:0]         r_slot;
    logic signed [pmrt_pkg::LO_W-1:0]    r_lo;
    logic [pmrt_pkg::MIN_PROD_W-1:0]     w_min_prod;
    logic [pmrt_pkg::SLOT_PROD_W-1:0]    w_quot_prod;
    logic [pmrt_pkg::TAG_W-1:0]          w_rem;

    // Bucket index counter.
    logic [pmrt_pkg::SLOT_W-1:0]         r_cnt;

    // Running state.
    logic [pmrt_pkg::COUNT_W-1:0]        r_total;
    logic [pmrt_pkg::TIME_W-1:0]         r_first;
    logic [pmrt_pkg::TIME_W-1:0]         r_last;
    logic [pmrt_pkg::COUNT_W-1:0]        r_acc;
    logic                                r_acc_vld;

    // Result registers.
    logic                                r_valid;
    logic [pmrt_pkg::COUNT_W-1:0]        r_out_window;
    logic [pmrt_pkg::COUNT_W-1:0]        r_out_total;
    logic [pmrt_pkg::TIME_W-1:0]         r_out_first;
    logic [pmrt_pkg::TIME_W-1:0]         r_out_last;

    // Bucket store interface.
    logic                                w_wr_en;
    logic [pmrt_pkg::SLOT_W-1:0]         w_wr_addr;
    logic [pmrt_pkg::WORD_W-1:0]         w_wr_data;
    logic [pmrt_pkg::SLOT_W-1:0]         w_rd_addr;
    logic [pmrt_pkg::WORD_W-1:0]         w_rd_data;
    logic [pmrt_pkg::TAG_W-1:0]          w_rd_tag;
    logic [pmrt_pkg::COUNT_W-1:0]        w_rd_count;
    logic [pmrt_pkg::COUNT_W-1:0]        w_new_count;
    logic signed [pmrt_pkg::LO_W-1:0]    w_tag_s;
    logic                                w_in_window;

    // Capture the input word when the item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op   <= i_opcode;
            r_secs <= i_time_seconds;
            r_win  <= i_window_minutes;
        end
    end

    // Minute number by reciprocal multiplication, then the slot in two more steps.
    assign w_min_prod  = pmrt_pkg::MIN_PROD_W'(r_secs)
                       * pmrt_pkg::MIN_PROD_W'(pmrt_pkg::MIN_MAGIC);
    assign w_quot_prod = pmrt_pkg::SLOT_PROD_W'(r_minute)
                       * pmrt_pkg::SLOT_PROD_W'(pmrt_pkg::SLOT_MAGIC);
    assign w_rem       = r_minute
                       - pmrt_pkg::TAG_W'(r_quot * pmrt_pkg::TAG_W'(pmrt_pkg::NUM_BUCKETS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_minute) begin
            r_minute <= w_min_prod[pmrt_pkg::MIN_SHIFT +: pmrt_pkg::TAG_W];
        end
        if (i_cmd.do_quot) begin
            r_quot <= w_quot_prod[pmrt_pkg::SLOT_SHIFT +: pmrt_pkg::TAG_W];
        end
        if (i_cmd.do_slot) begin
            r_slot <= w_rem[pmrt_pkg::SLOT_W-1:0];
            r_lo   <= $signed({2'b00, r_minute}) - $signed(pmrt_pkg::LO_W'(r_win));
        end
    end

    // Bucket index counter for the clearing sweep and the query scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Bucket word fields and the updated count for an add.
    assign w_rd_tag    = w_rd_data[pmrt_pkg::TAG_W-1:0];
    assign w_rd_count  = w_rd_data[pmrt_pkg::TAG_W +: pmrt_pkg::COUNT_W];
    assign w_new_count = (w_rd_tag == r_minute) ? (w_rd_count + 1'b1)
                                                : pmrt_pkg::COUNT_W'(1);

    // Store port selection.
    assign w_wr_en   = i_cmd.wr_clear | i_cmd.wr_add;
    assign w_wr_addr = i_cmd.wr_add ? r_slot : r_cnt;
    assign w_wr_data = i_cmd.wr_add ? {w_new_count, r_minute} : '0;
    assign w_rd_addr = i_cmd.rd_slot ? r_slot : r_cnt;

    pmrt_ram #(
        .WIDTH (pmrt_pkg::WORD_W),
        .DEPTH (pmrt_pkg::NUM_BUCKETS)
    ) u_bucket_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Message total and first and last times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else if (i_cmd.wr_add) begin
            r_total <= r_total + 1'b1;
            r_last  <= r_secs;
            if (r_first == '0) begin
                r_first <= r_secs;
            end
        end
    end

    // Window test on the bucket read in the previous cycle.
    assign w_tag_s     = $signed({2'b00, w_rd_tag});
    assign w_in_window = (w_tag_s >= r_lo) && (w_rd_tag <= r_minute);

    // Window sum over the scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.rd_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_acc_vld && w_in_window) begin
            r_acc <= r_acc + w_rd_count;
        end
    end

    // Result registers and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_window <= (r_op == pmrt_pkg::OP_QUERY) ? r_acc : '0;
            r_out_total  <= r_total;
            r_out_first  <= r_first;
            r_out_last   <= r_last;
        end
    end

    assign o_sts.cnt_last = (r_cnt == pmrt_pkg::LAST_SLOT);
    assign o_sts.is_query = (r_op == pmrt_pkg::OP_QUERY);

    assign o_valid        = r_valid;
    assign o_window_count = r_out_window;
    assign o_total_count  = r_out_total;
    assign o_first_time   = r_out_first;
    assign o_last_time    = r_out_last;

endmodule
